@@ design/iqws_pkg.sv @@
package iqws_pkg;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TAG_BITS_DEF    = 6;
    localparam int DATA_BITS_DEF   = 64;
    localparam int MAX_ISSUE       = 4;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_WAKE  = 2'd1,
        OP_ISSUE = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_ISSUED  = 2'd0,
        ST_ENQ_OK  = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOREADY = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_enq;
        logic do_wake;
        logic do_scan;
        logic do_remove;
        logic load_none;
        logic load_enq;
        logic load_full;
        logic set_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    found;
        logic    scan_end;
    } t_stat;
endpackage

@@ design/iqws_ctrl.sv @@
module iqws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic [2:0]     i_width,
    input  iqws_pkg::t_stat i_stat,
    output iqws_pkg::t_cmd  o_cmd
);
    import iqws_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DEC  = 5'b00010,
        S_SCAN = 5'b00100,
        S_OUT  = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [2:0] w_lim;
    logic       r_more, n_more;

    assign w_lim = (i_width == 3'd0) ? 3'd1 : ((i_width > 3'd4) ? 3'd4 : i_width);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // Sequencer: decode, scan for ready entries, present each result.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_more  = r_more;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_cnt = 3'd0;
                case (i_stat.op)
                    OP_ENQ: begin
                        if (i_stat.full) o_cmd.load_full = 1'b1;
                        else o_cmd.load_enq = 1'b1;
                        o_cmd.do_enq = ~i_stat.full;
                        o_cmd.set_last = 1'b1;
                        n_more = 1'b0;
                        n_state = S_OUT;
                    end
                    OP_WAKE: begin
                        o_cmd.do_wake = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_ISSUE: begin
                        o_cmd.do_scan = 1'b1;
                        n_state = S_SCAN;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                // Scan result registered in the datapath is now valid.
                if (i_stat.found) begin
                    o_cmd.do_remove = 1'b1;
                    n_cnt = r_cnt + 3'd1;
                    if ((r_cnt + 3'd1) < w_lim) begin
                        n_more = 1'b1;
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.set_last = 1'b1;
                        n_more = 1'b0;
                        n_state = S_OUT;
                    end
                end else if (r_cnt == 3'd0) begin
                    o_cmd.load_none = 1'b1;
                    o_cmd.set_last = 1'b1;
                    n_more = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WAIT: begin
                // Look ahead in the compacted queue; if nothing more is found,
                // the held result is marked last before it is offered.
                o_cmd.do_scan = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_more && i_stat.found) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_more  <= n_more;
        end
    end
endmodule

@@ design/iqws_dp.sv @@
module iqws_dp #(
    parameter int QUEUE_DEPTH = iqws_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = iqws_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS   = iqws_pkg::DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iqws_pkg::t_cmd        i_cmd,
    output iqws_pkg::t_stat       o_stat,
    input  logic [1:0]           i_opcode,
    input  logic [3:0]           i_alu_op,
    input  logic [TAG_BITS-1:0]  i_dest_tag,
    input  logic [TAG_BITS-1:0]  i_a_tag,
    input  logic                 i_a_rdy,
    input  logic [DATA_BITS-1:0] i_a_val,
    input  logic [TAG_BITS-1:0]  i_b_tag,
    input  logic                 i_b_rdy,
    input  logic [DATA_BITS-1:0] i_b_val,
    input  logic [31:0]          i_pc,
    input  logic                 i_exc,
    input  logic [DATA_BITS-1:0] i_wake,
    output logic [1:0]           o_status,
    output logic [3:0]           o_alu_op,
    output logic [TAG_BITS-1:0]  o_dest_tag,
    output logic [DATA_BITS-1:0] o_a_val,
    output logic [DATA_BITS-1:0] o_b_val,
    output logic [31:0]          o_pc,
    output logic [5:0]           o_occ,
    output logic                 o_last
);
    import iqws_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Entry storage: the rows shift as a compacting queue, each read in place.
    logic [3:0]           r_op  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  r_dst [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  r_at  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  r_bt  [QUEUE_DEPTH];
    logic                 r_ar  [QUEUE_DEPTH];
    logic                 r_br  [QUEUE_DEPTH];
    logic                 r_ex  [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] r_av  [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] r_bv  [QUEUE_DEPTH];
    logic [31:0]          r_pcs [QUEUE_DEPTH];
    logic [CW-1:0]        r_count;

    // Captured request.
    logic [1:0]           r_opc;
    logic [3:0]           r_alu;
    logic [TAG_BITS-1:0]  r_dt, r_at_i, r_bt_i;
    logic                 r_ar_i, r_br_i, r_ex_i;
    logic [DATA_BITS-1:0] r_av_i, r_bv_i, r_wk;
    logic [31:0]          r_pc_i;

    logic          r_found;
    logic [IW-1:0] r_sel;
    logic          w_found;
    logic [IW-1:0] w_sel;
    logic          w_stop;
    logic [QUEUE_DEPTH-1:0] w_live;

    assign o_stat.op       = t_opcode'(r_opc);
    assign o_stat.full     = (r_count >= CW'(QUEUE_DEPTH));
    assign o_stat.found    = r_found;
    assign o_stat.scan_end = ~r_found;

    // Oldest ready entry before the first exception entry.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        w_stop  = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_live[i] = (CW'(i) < r_count);
            if (w_live[i] && !w_found && !w_stop) begin
                if (r_ex[i]) w_stop = 1'b1;
                else if (r_ar[i] && r_br[i]) begin
                    w_found = 1'b1;
                    w_sel   = IW'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.do_scan) r_found <= w_found;
            if (i_cmd.do_enq) r_count <= r_count + CW'(1);
            if (i_cmd.do_remove) r_count <= r_count - CW'(1);
        end
    end

    // Request capture, select latch and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opc <= i_opcode; r_alu <= i_alu_op; r_dt <= i_dest_tag;
            r_at_i <= i_a_tag; r_ar_i <= i_a_rdy; r_av_i <= i_a_val;
            r_bt_i <= i_b_tag; r_br_i <= i_b_rdy; r_bv_i <= i_b_val;
            r_pc_i <= i_pc; r_ex_i <= i_exc; r_wk <= i_wake;
        end
        if (i_cmd.do_scan) r_sel <= w_sel;
        if (i_cmd.load_enq || i_cmd.load_full || i_cmd.load_none) begin
            o_status   <= i_cmd.load_enq ? ST_ENQ_OK :
                          (i_cmd.load_full ? ST_FULL : ST_NOREADY);
            o_alu_op   <= '0; o_dest_tag <= '0; o_a_val <= '0;
            o_b_val    <= '0; o_pc <= '0;
            o_occ      <= 6'(r_count + (i_cmd.load_enq ? CW'(1) : CW'(0)));
        end
        if (i_cmd.do_remove) begin
            o_status   <= ST_ISSUED;
            o_alu_op   <= r_op[r_sel]; o_dest_tag <= r_dst[r_sel];
            o_a_val    <= r_av[r_sel]; o_b_val <= r_bv[r_sel];
            o_pc       <= r_pcs[r_sel];
            o_occ      <= 6'(r_count - CW'(1));
        end
        if (i_cmd.load_enq || i_cmd.load_full || i_cmd.load_none || i_cmd.do_remove)
            o_last <= i_cmd.set_last;
        else if (i_cmd.do_scan && !w_found)
            o_last <= 1'b1;
    end

    // Queue update: append, broadcast wakeup, or remove and compact.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.do_enq && (CW'(i) == r_count)) begin
                r_op[i] <= r_alu; r_dst[i] <= r_dt;
                r_at[i] <= r_at_i; r_ar[i] <= r_ar_i; r_av[i] <= r_av_i;
                r_bt[i] <= r_bt_i; r_br[i] <= r_br_i; r_bv[i] <= r_bv_i;
                r_pcs[i] <= r_pc_i; r_ex[i] <= r_ex_i;
            end
            if (i_cmd.do_wake && w_live[i]) begin
                if (!r_ar[i] && r_at[i] == r_dt) begin
                    r_ar[i] <= 1'b1; r_av[i] <= r_wk;
                end
                if (!r_br[i] && r_bt[i] == r_dt) begin
                    r_br[i] <= 1'b1; r_bv[i] <= r_wk;
                end
            end
            if (i_cmd.do_remove && (i >= int'(r_sel)) && (i + 1 < QUEUE_DEPTH)) begin
                r_op[i] <= r_op[i+1]; r_dst[i] <= r_dst[i+1];
                r_at[i] <= r_at[i+1]; r_ar[i] <= r_ar[i+1]; r_av[i] <= r_av[i+1];
                r_bt[i] <= r_bt[i+1]; r_br[i] <= r_br[i+1]; r_bv[i] <= r_bv[i+1];
                r_pcs[i] <= r_pcs[i+1]; r_ex[i] <= r_ex[i+1];
            end
        end
    end
endmodule

@@ design/issue_queue_wakeup_select_top.sv @@
// Issue queue with tag wakeup and oldest-first select.
// s_axis carries one request: enqueue, wakeup broadcast or issue request,
// chosen by tuser. m_axis returns results: one for an enqueue (accepted or
// full), none for a wakeup, and one per issued entry (or one "nothing ready")
// for an issue request, the final one marked by tlast.
// cfg carries issue_width; write it only while the block is idle.
// Sequence: a request is taken only in the idle state. An enqueue is decoded
// and its result is then offered; a wakeup is applied in the decode state. An
// issue request scans the queue in its decode state; then per issued entry the
// block removes the entry, runs a look-ahead scan of the compacted queue that
// decides tlast, and offers the result; the entry that reaches issue_width
// skips the look-ahead. If nothing is ready, the nothing-ready result is
// offered after the scan.
// Reset empties the queue and sets issue_width to 4; slot contents are not
// cleared. When the receiver stalls, the result is held in the output register
// and no further request is taken until all results are delivered.
module issue_queue_wakeup_select_top #(
    parameter int QUEUE_DEPTH = iqws_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS    = iqws_pkg::TAG_BITS_DEF,
    parameter int DATA_BITS   = iqws_pkg::DATA_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: alu_op, dest_tag, src_a_tag, src_a_ready, src_a_value, src_b_tag,
    // src_b_ready, src_b_value, pc, exception flag, wake_value, zero fill
    input  logic [((4+3*TAG_BITS+3*DATA_BITS+35)+7)/8*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_alu_op, out_dest_tag, out_a_value, out_b_value, out_pc,
    // occupancy, zero fill
    output logic [((42+TAG_BITS+2*DATA_BITS)+7)/8*8-1:0] m_axis_tdata,
    // tuser: status
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_data
);
    import iqws_pkg::*;

    localparam int T = TAG_BITS;
    localparam int D = DATA_BITS;
    localparam int OW = 42 + T + 2*D;
    localparam int OP = (OW + 7) / 8 * 8;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [2:0] r_width;
    logic [3:0] w_alu;
    logic [T-1:0] w_dt;
    logic [D-1:0] w_av, w_bv;
    logic [31:0] w_pc;
    logic [5:0] w_occ;

    // Configuration register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_width <= 3'd4;
        else if (i_cfg_valid) r_width <= i_cfg_data;
    end

    iqws_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_width(r_width), .i_stat(w_stat), .o_cmd(w_cmd)
    );

    iqws_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(T), .DATA_BITS(D)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_opcode(s_axis_tuser),
        .i_alu_op(s_axis_tdata[3:0]),
        .i_dest_tag(s_axis_tdata[4 +: T]),
        .i_a_tag(s_axis_tdata[4+T +: T]),
        .i_a_rdy(s_axis_tdata[4+2*T]),
        .i_a_val(s_axis_tdata[5+2*T +: D]),
        .i_b_tag(s_axis_tdata[5+2*T+D +: T]),
        .i_b_rdy(s_axis_tdata[5+3*T+D]),
        .i_b_val(s_axis_tdata[6+3*T+D +: D]),
        .i_pc(s_axis_tdata[6+3*T+2*D +: 32]),
        .i_exc(s_axis_tdata[38+3*T+2*D]),
        .i_wake(s_axis_tdata[39+3*T+2*D +: D]),
        .o_status(m_axis_tuser), .o_alu_op(w_alu), .o_dest_tag(w_dt),
        .o_a_val(w_av), .o_b_val(w_bv), .o_pc(w_pc), .o_occ(w_occ),
        .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = OP'({w_occ, w_pc, w_bv, w_av, w_dt, w_alu});
endmodule

@@ design/iqws_checker.sv @@
module iqws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);
    import iqws_pkg::*;

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // No request is taken while a result is offered.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken during output");

    // Enqueue, full and nothing-ready results always close their request.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_ISSUED) |-> m_axis_tlast)
        else $error("non-issue result not marked last");

    // A request never produces a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
endmodule

bind issue_queue_wakeup_select_top iqws_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tlast
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import iqws_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    // One request on the slave stream.
    typedef struct {
        t_opcode     op;
        logic [3:0]  alu_op;
        logic [5:0]  dest_tag;
        logic [5:0]  a_tag;
        logic        a_rdy;
        logic [63:0] a_val;
        logic [5:0]  b_tag;
        logic        b_rdy;
        logic [63:0] b_val;
        logic [31:0] pc;
        logic        exc;
        logic [63:0] wake_val;
    } t_req;

    // One result on the master stream.
    typedef struct {
        t_status     status;
        logic [3:0]  alu_op;
        logic [5:0]  dest_tag;
        logic [63:0] a_val;
        logic [63:0] b_val;
        logic [31:0] pc;
        logic [5:0]  occ;
        logic        last;
    } t_res;

    // Directed row: a request and, where obvious, its typed-in result.
    typedef struct {
        t_req        req;
        logic        has_exp;
        t_status     exp_status;
        logic [5:0]  exp_occ;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [255:0]   s_axis_tdata;
    logic [1:0]     s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [175:0]   m_axis_tdata;
    logic [1:0]     m_axis_tuser;
    logic           m_axis_tlast;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_data;

    // Predicted queue contents, oldest first, and the predicted width register.
    t_req           iq_entries[$];
    logic [2:0]     cur_width;
    t_res           pending_results[$];
    int             errors;
    int             cycles;
    bit             no_idle;
    int             stall_left;

    issue_queue_wakeup_select_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Run-time guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        if (no_idle) begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [255:0] pack_req(t_req r);
        return {7'b0, r.wake_val, r.exc, r.pc, r.b_val, r.b_rdy, r.b_tag,
                r.a_val, r.a_rdy, r.a_tag, r.dest_tag, r.alu_op};
    endfunction

    function automatic t_res blank_result(t_status st);
        t_res r;
        r = '{status: st, alu_op: '0, dest_tag: '0, a_val: '0, b_val: '0,
              pc: '0, occ: '0, last: 1'b0};
        return r;
    endfunction

    // Predict the results of one accepted request and update the queue copy.
    task automatic apply_request(t_req r);
        t_res res;
        int   width;
        int   idx;
        int   n;
        case (r.op)
            OP_ENQ: begin
                if (iq_entries.size() >= DEPTH) begin
                    res = blank_result(ST_FULL);
                end else begin
                    iq_entries.push_back(r);
                    res = blank_result(ST_ENQ_OK);
                end
                res.occ = 6'(iq_entries.size());
                res.last = 1'b1;
                pending_results.push_back(res);
            end
            OP_WAKE: begin
                // Only operands still waiting take the broadcast value.
                foreach (iq_entries[k]) begin
                    if (!iq_entries[k].a_rdy && iq_entries[k].a_tag == r.dest_tag) begin
                        iq_entries[k].a_rdy = 1'b1;
                        iq_entries[k].a_val = r.wake_val;
                    end
                    if (!iq_entries[k].b_rdy && iq_entries[k].b_tag == r.dest_tag) begin
                        iq_entries[k].b_rdy = 1'b1;
                        iq_entries[k].b_val = r.wake_val;
                    end
                end
            end
            OP_ISSUE: begin
                width = (cur_width < 1) ? 1 : (cur_width > MAX_ISSUE ? MAX_ISSUE : cur_width);
                idx = 0;
                n = 0;
                // Oldest-first walk; an exception entry blocks everything younger.
                while (idx < iq_entries.size() && n < width) begin
                    if (iq_entries[idx].exc) begin
                        break;
                    end
                    if (iq_entries[idx].a_rdy && iq_entries[idx].b_rdy) begin
                        res = blank_result(ST_ISSUED);
                        res.alu_op = iq_entries[idx].alu_op;
                        res.dest_tag = iq_entries[idx].dest_tag;
                        res.a_val = iq_entries[idx].a_val;
                        res.b_val = iq_entries[idx].b_val;
                        res.pc = iq_entries[idx].pc;
                        iq_entries.delete(idx);
                        res.occ = 6'(iq_entries.size());
                        pending_results.push_back(res);
                        n++;
                    end else begin
                        idx++;
                    end
                end
                if (n == 0) begin
                    res = blank_result(ST_NOREADY);
                    res.occ = 6'(iq_entries.size());
                    pending_results.push_back(res);
                end
                pending_results[pending_results.size() - 1].last = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // Send one request; returns just after the edge at which it was taken.
    task automatic send_request(t_req r);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_req(r);
        s_axis_tuser <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_request(r);
    endtask

    // Write issue_width once the block has drained.
    task automatic write_width(logic [2:0] w);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_width = w;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [5:0] rand_tag();
        if ($urandom_range(0, 3) != 0) begin
            return 6'($urandom_range(0, 7));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    // Random request; exceptions only when allowed since they clog the queue.
    function automatic t_req random_request(bit allow_exc, int enq_weight);
        t_req r;
        int   pick;
        int   k;
        r.alu_op = 4'($urandom_range(0, 15));
        r.dest_tag = rand_tag();
        r.a_tag = rand_tag();
        r.a_rdy = 1'($urandom_range(0, 1));
        r.a_val = {$urandom, $urandom};
        r.b_tag = rand_tag();
        r.b_rdy = 1'($urandom_range(0, 1));
        r.b_val = {$urandom, $urandom};
        r.pc = $urandom;
        r.exc = allow_exc && ($urandom_range(0, 9) == 0);
        r.wake_val = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < enq_weight) begin
            r.op = OP_ENQ;
        end else if (pick < enq_weight + (100 - enq_weight) / 2) begin
            r.op = OP_WAKE;
            // Mostly target a tag that some entry is really waiting on.
            if (iq_entries.size() != 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, iq_entries.size() - 1);
                r.dest_tag = iq_entries[k].a_rdy ? iq_entries[k].b_tag : iq_entries[k].a_tag;
            end
        end else if (pick < 96) begin
            r.op = OP_ISSUE;
        end else begin
            r.op = OP_NONE;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d", m_axis_tuser);
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", 64'(e.status), 64'(m_axis_tuser));
                check_field("out_alu_op", 64'(e.alu_op), 64'(m_axis_tdata[3:0]));
                check_field("out_dest_tag", 64'(e.dest_tag), 64'(m_axis_tdata[9:4]));
                check_field("out_a_value", e.a_val, m_axis_tdata[73:10]);
                check_field("out_b_value", e.b_val, m_axis_tdata[137:74]);
                check_field("out_pc", 64'(e.pc), 64'(m_axis_tdata[169:138]));
                check_field("occupancy", 64'(e.occ), 64'(m_axis_tdata[175:170]));
                check_field("last", 64'(e.last), 64'(m_axis_tlast));
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    // Stimulus.
    initial begin
        t_row        rows[$];
        t_row        row;
        t_req        base;
        t_res        fixed_res;
        logic [2:0]  widths[7];
        int          n_items;

        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        stall_left = 0;
        cur_width = 3'd4;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_NONE;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        base = '{op: OP_ISSUE, alu_op: '0, dest_tag: '0, a_tag: '0, a_rdy: 1'b0,
                 a_val: '0, b_tag: '0, b_rdy: 1'b0, b_val: '0, pc: '0, exc: 1'b0,
                 wake_val: '0};
        row = '{req: base, has_exp: 1'b1, exp_status: ST_NOREADY, exp_occ: 6'd0};
        rows.push_back(row);
        row.req.op = OP_NONE;
        row.has_exp = 1'b0;
        rows.push_back(row);
        // All-ones entry, both operands ready.
        row.req = '{op: OP_ENQ, alu_op: '1, dest_tag: '1, a_tag: '1, a_rdy: 1'b1,
                    a_val: '1, b_tag: '1, b_rdy: 1'b1, b_val: '1, pc: '1, exc: 1'b0,
                    wake_val: '1};
        row.has_exp = 1'b1;
        row.exp_status = ST_ENQ_OK;
        row.exp_occ = 6'd1;
        rows.push_back(row);
        // All-zero entry, operand A waits on tag 0.
        row.req = base;
        row.req.op = OP_ENQ;
        row.req.b_rdy = 1'b1;
        row.exp_occ = 6'd2;
        rows.push_back(row);
        // Both operands wait on tag 63.
        row.req.a_tag = 6'd63;
        row.req.b_tag = 6'd63;
        row.req.b_rdy = 1'b0;
        row.req.pc = 32'h8000_0000;
        row.exp_occ = 6'd3;
        rows.push_back(row);
        // Issue takes only the ready oldest entry.
        row.req = base;
        row.has_exp = 1'b0;
        rows.push_back(row);
        // Broadcast on a ready operand's tag must not overwrite it.
        row.req.op = OP_WAKE;
        row.req.dest_tag = 6'd63;
        row.req.wake_val = 64'h5555_5555_5555_5555;
        rows.push_back(row);
        row.req.dest_tag = 6'd0;
        row.req.wake_val = '1;
        rows.push_back(row);
        row.req.op = OP_ISSUE;
        rows.push_back(row);
        row.req.op = OP_ISSUE;
        rows.push_back(row);

        foreach (rows[i]) begin
            send_request(rows[i].req);
            if (rows[i].has_exp) begin
                fixed_res = blank_result(rows[i].exp_status);
                fixed_res.occ = rows[i].exp_occ;
                fixed_res.last = 1'b1;
                void'(pending_results.pop_back());
                pending_results.push_back(fixed_res);
            end
        end

        // Random phases over several widths, extremes and out-of-range included.
        widths = '{3'd1, 3'd0, 3'd7, 3'd4, 3'd2, 3'd5, 3'd3};
        foreach (widths[p]) begin
            write_width(widths[p]);
            no_idle = (p == 3);
            n_items = $urandom_range(5, 8);
            repeat (n_items) send_request(random_request(1'b0, 40));
        end
        no_idle = 1'b0;

        // Final phase: exceptions appear and the queue fills to full.
        write_width(3'd4);
        repeat (12) send_request(random_request(1'b1, 70));
        repeat (DEPTH + 2) begin
            base = random_request(1'b1, 100);
            send_request(base);
        end
        send_request(random_request(1'b1, 0));

        // Drain.
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("results still expected: %0d", pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
